// ===== src/kuap_pkg.sv =====
package kuap_pkg;

    localparam int MAX_PREFIX_BYTES = 8;
    localparam int NAME_COUNT       = 7;
    localparam int NAME_BITS        = 104;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_KEY,
        PH_VALUE,
        PH_PCT1,
        PH_PCT2,
        PH_SKIP,
        PH_QSTART,
        PH_ERROR
    } phase_t;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_PREFIX = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_ATTR   = 3'd3;
    localparam logic [2:0] ST_DUP    = 3'd4;

    localparam logic CFG_PREFIX_TEXT   = 1'b0;
    localparam logic CFG_PREFIX_LENGTH = 1'b1;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PCT   = 8'h25;

    localparam logic [6:0] PATH_SET  = 7'h1F;
    localparam logic [6:0] QUERY_SET = 7'h60;

    localparam logic [NAME_BITS-1:0] NAME_TEXT [0:NAME_COUNT-1] = '{
        NAME_BITS'("origin-type"),
        NAME_BITS'("origin-alg"),
        NAME_BITS'("origin-blob"),
        NAME_BITS'("origin-pubkey"),
        NAME_BITS'("comment"),
        NAME_BITS'("mkvp"),
        NAME_BITS'("apqns")
    };

    localparam logic [3:0] NAME_LEN [0:NAME_COUNT-1] = '{
        4'd11, 4'd10, 4'd11, 4'd13, 4'd7, 4'd4, 4'd5
    };

    // result slots carried by one queue entry
    localparam int SLOT_FIRST  = 0;
    localparam int SLOT_END    = 1;
    localparam int SLOT_STATUS = 2;

    typedef struct packed {
        logic [2:0] mask;
        logic       first_end;
        logic [2:0] attr;
        logic [7:0] data;
        logic [2:0] status;
    } res_rec_t;

    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [3:0] pos);
        logic [NAME_BITS-1:0] txt;
        logic [3:0]           len;
        logic [3:0]           off;
        name_char = 8'd0;
        if (idx < 3'(NAME_COUNT)) begin
            txt = NAME_TEXT[idx];
            len = NAME_LEN[idx];
            if (pos < len) begin
                off       = len - 4'd1 - pos;
                name_char = txt[{off, 3'b000} +: 8];
            end
        end
    endfunction

    function automatic logic hex_ok(input logic [7:0] b);
        hex_ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                 (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h57;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = b - 8'h37;
        end
        hex_nib = v[3:0];
    endfunction

endpackage

// ===== src/kuap_front.sv =====
module kuap_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data,
    output logic                 push_valid,
    input  logic                 push_ready,
    output kuap_pkg::res_rec_t   push_rec
);
    import kuap_pkg::*;

    logic [63:0] prefix_text_reg;
    logic [3:0]  prefix_length_reg;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  ppos_reg,     ppos_next;
    logic [6:0]  cand_reg,     cand_next;
    logic [3:0]  kpos_reg,     kpos_next;
    logic [2:0]  attr_reg,     attr_next;
    logic [3:0]  hi_reg,       hi_next;
    logic [6:0]  seen_reg,     seen_next;
    logic        inq_reg,      inq_next;
    logic        nonempty_reg, nonempty_next;
    logic [2:0]  err_reg,      err_next;

    logic        fire;
    logic [3:0]  plen;
    logic [7:0]  b;
    logic [6:0]  kc;
    logic [3:0]  kp;
    logic [6:0]  keep;
    logic        found;
    logic [2:0]  hit;
    logic [2:0]  fin_code;
    res_rec_t    rec;

    assign s_tready   = push_ready;
    assign cfg_ready  = 1'b1;
    assign fire       = s_tvalid && s_tready;
    assign push_valid = fire && (rec.mask != 3'd0);
    assign push_rec   = rec;

    always_comb begin
        phase_next    = phase_reg;
        ppos_next     = ppos_reg;
        cand_next     = cand_reg;
        kpos_next     = kpos_reg;
        attr_next     = attr_reg;
        hi_next       = hi_reg;
        seen_next     = seen_reg;
        inq_next      = inq_reg;
        nonempty_next = nonempty_reg;
        err_next      = err_reg;
        rec           = '0;
        b             = s_tdata;
        kc            = cand_reg;
        kp            = kpos_reg;
        keep          = 7'd0;
        found         = 1'b0;
        hit           = 3'd0;
        fin_code      = ST_OK;
        plen          = (prefix_length_reg > 4'(MAX_PREFIX_BYTES)) ?
                        4'(MAX_PREFIX_BYTES) : prefix_length_reg;

        unique case (phase_reg)
            PH_PREFIX: begin
                if (ppos_reg < plen) begin
                    if (b == prefix_text_reg[{ppos_reg[2:0], 3'b000} +: 8]) begin
                        ppos_next = ppos_reg + 4'd1;
                    end else begin
                        phase_next = PH_ERROR;
                        err_next   = (err_reg == ST_OK) ? ST_PREFIX : err_reg;
                    end
                end else if (b == CH_COLON) begin
                    inq_next   = 1'b0;
                    phase_next = PH_KEY;
                    kpos_next  = 4'd0;
                    cand_next  = PATH_SET;
                end else begin
                    phase_next = PH_ERROR;
                    err_next   = (err_reg == ST_OK) ? ST_PREFIX : err_reg;
                end
            end
            PH_QSTART: begin
                phase_next = PH_KEY;
                kpos_next  = 4'd0;
                cand_next  = QUERY_SET;
                kc         = QUERY_SET;
                kp         = 4'd0;
            end
            PH_KEY: begin
            end
            PH_VALUE, PH_PCT1, PH_PCT2, PH_SKIP: begin
                rec.attr = attr_reg;
                if (!inq_reg && (b == CH_SEMI || b == CH_QUERY)) begin
                    rec.mask[SLOT_FIRST] = 1'b1;
                    rec.first_end        = 1'b1;
                    if (b == CH_QUERY) begin
                        inq_next   = 1'b1;
                        phase_next = PH_QSTART;
                    end else begin
                        phase_next = PH_KEY;
                        kpos_next  = 4'd0;
                        cand_next  = PATH_SET;
                    end
                end else if (inq_reg && b == CH_AMP) begin
                    rec.mask[SLOT_FIRST] = 1'b1;
                    rec.first_end        = 1'b1;
                    phase_next           = PH_KEY;
                    kpos_next            = 4'd0;
                    cand_next            = QUERY_SET;
                end else begin
                    priority case (phase_reg)
                        PH_VALUE: begin
                            if (b == CH_PCT) begin
                                phase_next = PH_PCT1;
                            end else begin
                                rec.mask[SLOT_FIRST] = 1'b1;
                                rec.data             = b;
                            end
                        end
                        PH_PCT1: begin
                            if (hex_ok(b)) begin
                                hi_next    = hex_nib(b);
                                phase_next = PH_PCT2;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                        PH_PCT2: begin
                            if (hex_ok(b)) begin
                                rec.mask[SLOT_FIRST] = 1'b1;
                                rec.data             = {hi_reg, hex_nib(b)};
                                phase_next           = PH_VALUE;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            PH_ERROR: begin
            end
        endcase

        // key matching, shared by a key byte and the first byte of the query
        if (phase_reg == PH_KEY || phase_reg == PH_QSTART) begin
            if (b == CH_EQUAL) begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (!found && kc[i] && NAME_LEN[i] == kp) begin
                        found = 1'b1;
                        hit   = 3'(i);
                    end
                end
                if (found) begin
                    if (seen_reg[hit]) begin
                        phase_next = PH_ERROR;
                        err_next   = (err_reg == ST_OK) ? ST_DUP : err_reg;
                    end else begin
                        seen_next[hit] = 1'b1;
                        attr_next      = hit;
                        phase_next     = PH_VALUE;
                    end
                end else begin
                    phase_next = PH_ERROR;
                    err_next   = (err_reg == ST_OK) ? ST_ATTR : err_reg;
                end
            end else if (!inq_reg && b == CH_QUERY && kp == 4'd0 && !nonempty_reg) begin
                phase_next = PH_ERROR;
                err_next   = (err_reg == ST_OK) ? ST_EMPTY : err_reg;
            end else if ((!inq_reg && (b == CH_SEMI || b == CH_QUERY)) ||
                         (inq_reg && b == CH_AMP)) begin
                phase_next = PH_ERROR;
                err_next   = (err_reg == ST_OK) ? ST_ATTR : err_reg;
            end else begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    keep[i] = kc[i] && (kp < NAME_LEN[i]) && (name_char(3'(i), kp) == b);
                end
                if (keep == 7'd0) begin
                    phase_next = PH_ERROR;
                    err_next   = (err_reg == ST_OK) ? ST_ATTR : err_reg;
                end else begin
                    cand_next = keep;
                    if (kp < 4'd15) begin
                        kpos_next = kp + 4'd1;
                    end
                end
            end
            if (phase_reg == PH_KEY && !inq_reg && b != CH_QUERY) begin
                nonempty_next = 1'b1;
            end
        end

        if (s_tlast) begin
            rec.attr = attr_next;
            unique case (phase_next)
                PH_PREFIX: begin
                    fin_code = ST_PREFIX;
                end
                PH_KEY: begin
                    fin_code = (!inq_next && !nonempty_next) ? ST_EMPTY : ST_ATTR;
                end
                PH_VALUE, PH_PCT1, PH_PCT2, PH_SKIP: begin
                    rec.mask[SLOT_END] = 1'b1;
                end
                PH_QSTART, PH_ERROR: begin
                end
            endcase
            if (fin_code != ST_OK && err_next == ST_OK) begin
                err_next = fin_code;
            end
            rec.mask[SLOT_STATUS] = 1'b1;
            rec.status            = err_next;
            phase_next            = PH_PREFIX;
            ppos_next             = 4'd0;
            cand_next             = 7'h7F;
            kpos_next             = 4'd0;
            attr_next             = 3'd0;
            hi_next               = 4'd0;
            seen_next             = 7'd0;
            inq_next              = 1'b0;
            nonempty_next         = 1'b0;
            err_next              = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_text_reg   <= 64'd0;
            prefix_length_reg <= 4'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PREFIX_TEXT:   prefix_text_reg   <= cfg_data;
                CFG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[3:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_PREFIX;
            ppos_reg     <= 4'd0;
            cand_reg     <= 7'h7F;
            kpos_reg     <= 4'd0;
            attr_reg     <= 3'd0;
            hi_reg       <= 4'd0;
            seen_reg     <= 7'd0;
            inq_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
            err_reg      <= ST_OK;
        end else if (fire) begin
            phase_reg    <= phase_next;
            ppos_reg     <= ppos_next;
            cand_reg     <= cand_next;
            kpos_reg     <= kpos_next;
            attr_reg     <= attr_next;
            hi_reg       <= hi_next;
            seen_reg     <= seen_next;
            inq_reg      <= inq_next;
            nonempty_reg <= nonempty_next;
            err_reg      <= err_next;
        end
    end

endmodule

// ===== src/kuap_queue.sv =====
module kuap_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  kuap_pkg::res_rec_t   push_rec,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output kuap_pkg::res_rec_t   pop_rec
);
    import kuap_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    res_rec_t        mem_reg [0:DEPTH-1];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/kuap_back.sv =====
module kuap_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    output logic                 rec_pop,
    input  kuap_pkg::res_rec_t   rec,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);
    import kuap_pkg::*;

    logic [2:0] done_reg,  done_next;
    logic       valid_reg, valid_next;
    logic [1:0] kind_reg,  kind_next;
    logic [2:0] attr_reg,  attr_next;
    logic [7:0] data_reg,  data_next;
    logic [2:0] stat_reg,  stat_next;
    logic       last_reg,  last_next;

    logic [2:0] pending;
    logic [2:0] sel;
    logic       out_free;
    logic       load;

    assign pending  = rec.mask & ~done_reg;
    assign sel      = pending & (~pending + 3'd1);
    assign out_free = !valid_reg || m_tready;
    assign load     = rec_valid && out_free;
    assign rec_pop  = load && ((pending & ~sel) == 3'd0);

    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg && !m_tready;
        kind_next  = kind_reg;
        attr_next  = attr_reg;
        data_next  = data_reg;
        stat_next  = stat_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            done_next  = rec_pop ? 3'd0 : (done_reg | sel);
            priority if (sel[SLOT_FIRST]) begin
                kind_next = rec.first_end ? KIND_END : KIND_BYTE;
                attr_next = rec.attr;
                data_next = rec.data;
                stat_next = ST_OK;
                last_next = 1'b0;
            end else if (sel[SLOT_END]) begin
                kind_next = KIND_END;
                attr_next = rec.attr;
                data_next = 8'd0;
                stat_next = ST_OK;
                last_next = 1'b0;
            end else begin
                kind_next = KIND_STATUS;
                attr_next = 3'd0;
                data_next = 8'd0;
                stat_next = rec.status;
                last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        attr_reg <= attr_next;
        data_reg <= data_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {2'b00, stat_reg, data_reg, attr_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== src/key_uri_attribute_parser.sv =====
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | s_tdata = URI byte, s_tlast = final byte
// m_       | out       | m_tvalid/m_tready  | m_tuser = kind, m_tdata = id/byte/status
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One URI byte is taken every cycle while the result queue has room.
// Each result occupies the output register until it is taken; a byte that
// yields two or three results holds the queue head until its last result is loaded.
// A result passes through its queue entry and then the output register before it appears.
// Reset is synchronous; no clearing pass follows it.
module key_uri_attribute_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] attr_id, [10:3] data_byte, [13:11] status
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import kuap_pkg::*;

    logic     q_push;
    logic     q_push_ready;
    res_rec_t q_push_rec;
    logic     q_pop_valid;
    logic     q_pop;
    res_rec_t q_pop_rec;

    kuap_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (q_push),
        .push_ready (q_push_ready),
        .push_rec   (q_push_rec)
    );

    kuap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push),
        .push_ready (q_push_ready),
        .push_rec   (q_push_rec),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop),
        .pop_rec    (q_pop_rec)
    );

    kuap_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (q_pop_valid),
        .rec_pop   (q_pop),
        .rec       (q_pop_rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_STATUS)))
        else $error("last flag and status kind disagree");

    a_final_byte_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> q_push)
        else $error("final byte accepted without a queued status");

    a_status_only_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[13:11] == ST_OK))
        else $error("status set on a non-final transaction");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import kuap_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } uri_char_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] attr;
        logic [7:0] data;
        logic [2:0] status;
        logic       fin;
    } parse_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data = 64'd0;

    key_uri_attribute_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // parser state mirror
    phase_t      pst;
    logic [3:0]  pfx_pos;
    logic [6:0]  key_cand;
    logic [3:0]  key_pos;
    logic [2:0]  cur_attr;
    logic [3:0]  hi_nib;
    logic [6:0]  seen;
    logic        in_q;
    logic        path_ne;
    logic [2:0]  err_code;
    logic [63:0] pfx_text;
    logic [3:0]  pfx_len;

    parse_res_t  results_due[$];
    uri_char_t   pending_chars[$];
    logic [7:0]  uri_buf[$];
    int          chars_queued = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          stall_tick = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    parse_res_t  got_res;
    parse_res_t  want_res;

    function automatic string attr_name(input int id);
        case (id)
            0: attr_name = "origin-type";
            1: attr_name = "origin-alg";
            2: attr_name = "origin-blob";
            3: attr_name = "origin-pubkey";
            4: attr_name = "comment";
            5: attr_name = "mkvp";
            default: attr_name = "apqns";
        endcase
    endfunction

    function automatic int hex_val(input logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            hex_val = int'(b) - int'("0");
        end else if (b >= "a" && b <= "f") begin
            hex_val = int'(b) - int'("a") + 10;
        end else if (b >= "A" && b <= "F") begin
            hex_val = int'(b) - int'("A") + 10;
        end else begin
            hex_val = -1;
        end
    endfunction

    task automatic add_result(input logic [1:0] kind, input logic [2:0] attr,
                              input logic [7:0] data, input logic [2:0] status,
                              input logic fin);
        results_due.push_back('{kind, attr, data, status, fin});
    endtask

    task automatic reset_uri();
        pst      = PH_PREFIX;
        pfx_pos  = 4'd0;
        key_cand = 7'h7F;
        key_pos  = 4'd0;
        cur_attr = 3'd0;
        hi_nib   = 4'd0;
        seen     = 7'd0;
        in_q     = 1'b0;
        path_ne  = 1'b0;
        err_code = ST_OK;
    endtask

    task automatic set_error(input logic [2:0] code);
        if (err_code == ST_OK) err_code = code;
        pst = PH_ERROR;
    endtask

    task automatic open_key();
        pst      = PH_KEY;
        key_pos  = 4'd0;
        key_cand = in_q ? QUERY_SET : PATH_SET;
    endtask

    task automatic key_char(input logic [7:0] b);
        int         i;
        logic [6:0] keep;
        string      nm;
        bit         done;
        keep = 7'd0;
        done = 1'b0;
        if (b == CH_EQUAL) begin
            for (i = 0; i < 7 && !done; i++) begin
                nm = attr_name(i);
                if (key_cand[i] && nm.len() == key_pos) begin
                    done = 1'b1;
                    if (seen[i]) begin
                        set_error(ST_DUP);
                    end else begin
                        seen[i]  = 1'b1;
                        cur_attr = 3'(i);
                        pst      = PH_VALUE;
                    end
                end
            end
            if (!done) set_error(ST_ATTR);
        end else if (!in_q && b == CH_QUERY && key_pos == 4'd0 && !path_ne) begin
            set_error(ST_EMPTY);
        end else if ((!in_q && (b == CH_SEMI || b == CH_QUERY)) || (in_q && b == CH_AMP)) begin
            set_error(ST_ATTR);
        end else begin
            for (i = 0; i < 7; i++) begin
                nm = attr_name(i);
                if (key_cand[i] && key_pos < nm.len() && nm[key_pos] == b) keep[i] = 1'b1;
            end
            if (keep == 7'd0) begin
                set_error(ST_ATTR);
            end else begin
                key_cand = keep;
                if (key_pos < 4'd15) key_pos = key_pos + 4'd1;
            end
        end
    endtask

    task automatic value_char(input logic [7:0] b);
        int h;
        h = hex_val(b);
        if (!in_q && (b == CH_SEMI || b == CH_QUERY)) begin
            add_result(KIND_END, cur_attr, 8'd0, ST_OK, 1'b0);
            if (b == CH_QUERY) begin
                in_q = 1'b1;
                pst  = PH_QSTART;
            end else begin
                open_key();
            end
        end else if (in_q && b == CH_AMP) begin
            add_result(KIND_END, cur_attr, 8'd0, ST_OK, 1'b0);
            open_key();
        end else begin
            case (pst)
                PH_VALUE: begin
                    if (b == CH_PCT) pst = PH_PCT1;
                    else add_result(KIND_BYTE, cur_attr, b, ST_OK, 1'b0);
                end
                PH_PCT1: begin
                    if (h < 0) begin
                        pst = PH_SKIP;
                    end else begin
                        hi_nib = 4'(h);
                        pst    = PH_PCT2;
                    end
                end
                PH_PCT2: begin
                    if (h < 0) begin
                        pst = PH_SKIP;
                    end else begin
                        add_result(KIND_BYTE, cur_attr, {hi_nib, 4'(h)}, ST_OK, 1'b0);
                        pst = PH_VALUE;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic predict_char(input logic [7:0] b, input logic fin);
        int eff_len;
        eff_len = (pfx_len > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : int'(pfx_len);
        case (pst)
            PH_PREFIX: begin
                if (pfx_pos < eff_len) begin
                    if (b == pfx_text[{pfx_pos[2:0], 3'b000} +: 8]) pfx_pos = pfx_pos + 4'd1;
                    else set_error(ST_PREFIX);
                end else if (b == CH_COLON) begin
                    in_q = 1'b0;
                    open_key();
                end else begin
                    set_error(ST_PREFIX);
                end
            end
            PH_QSTART: begin
                open_key();
                key_char(b);
            end
            PH_KEY: begin
                key_char(b);
                if (!in_q && b != CH_QUERY) path_ne = 1'b1;
            end
            PH_VALUE, PH_PCT1, PH_PCT2, PH_SKIP: value_char(b);
            default: ;
        endcase
        if (fin) begin
            case (pst)
                PH_PREFIX: set_error(ST_PREFIX);
                PH_KEY: begin
                    if (!in_q && !path_ne) set_error(ST_EMPTY);
                    else set_error(ST_ATTR);
                end
                PH_VALUE, PH_PCT1, PH_PCT2, PH_SKIP:
                    add_result(KIND_END, cur_attr, 8'd0, ST_OK, 1'b0);
                default: ;
            endcase
            add_result(KIND_STATUS, 3'd0, 8'd0, err_code, 1'b1);
            reset_uri();
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        uri_buf.push_back(b);
    endtask

    task automatic put_str(input string s);
        int j;
        for (j = 0; j < s.len(); j++) put_byte(s[j]);
    endtask

    task automatic put_name(input int id, input int cut);
        int    j;
        string nm;
        nm = attr_name(id);
        for (j = 0; j < nm.len() - cut; j++) put_byte(nm[j]);
    endtask

    task automatic flush_uri();
        int j;
        for (j = 0; j < uri_buf.size(); j++) begin
            pending_chars.push_back('{uri_buf[j], j == uri_buf.size() - 1});
        end
        chars_queued = chars_queued + uri_buf.size();
        uri_buf.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) hex_char = 8'h30 + 8'(v);
        else if ($urandom_range(0, 1)) hex_char = 8'h61 + 8'(v) - 8'd10;
        else hex_char = 8'h41 + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] nonhex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_val(b) >= 0);
        nonhex_byte = b;
    endfunction

    function automatic logic [7:0] plain_byte(input bit inq);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_PCT || (inq ? b == CH_AMP : (b == CH_SEMI || b == CH_QUERY)));
        plain_byte = b;
    endfunction

    task automatic put_value(input bit inq);
        int n;
        int i;
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                5: begin
                    put_byte(CH_PCT);
                    put_byte(hex_char(4'($urandom_range(0, 15))));
                    put_byte(hex_char(4'($urandom_range(0, 15))));
                end
                6: begin
                    put_byte(CH_PCT);
                    if ($urandom_range(0, 1)) put_byte(hex_char(4'($urandom_range(0, 15))));
                    put_byte(nonhex_byte());
                end
                7: begin
                    if (inq) begin
                        case ($urandom_range(0, 2))
                            0: put_byte(CH_SEMI);
                            1: put_byte(CH_EQUAL);
                            default: put_byte(CH_QUERY);
                        endcase
                    end else begin
                        put_byte($urandom_range(0, 1) ? CH_AMP : CH_EQUAL);
                    end
                end
                8: put_byte($urandom_range(0, 1) ? 8'h00 : 8'hFF);
                9: put_byte(CH_PCT);
                default: put_byte(plain_byte(inq));
            endcase
        end
    endtask

    task automatic put_element(input bit inq);
        int id;
        int other;
        id    = inq ? $urandom_range(5, 6) : $urandom_range(0, 4);
        other = inq ? $urandom_range(0, 4) : $urandom_range(5, 6);
        case ($urandom_range(0, 11))
            0: ;
            1: begin
                put_name(other, 0);
                put_byte(CH_EQUAL);
                put_value(inq);
            end
            2: put_name(id, 0);
            3: begin
                put_name(id, $urandom_range(1, 3));
                put_byte(CH_EQUAL);
                put_value(inq);
            end
            default: begin
                put_name(id, 0);
                put_byte(CH_EQUAL);
                put_value(inq);
            end
        endcase
    endtask

    task automatic gen_uri();
        int         n;
        int         i;
        int         k;
        int         eff;
        int         mode;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
        end else begin
            eff = (pfx_len > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : int'(pfx_len);
            for (i = 0; i < eff; i++) put_byte(pfx_text[8*i +: 8]);
            mode = $urandom_range(0, 19);
            if (mode == 1 && eff > 0) begin
                k = $urandom_range(0, eff - 1);
                uri_buf[k] = uri_buf[k] ^ (8'd1 << $urandom_range(0, 7));
            end
            if (mode != 0) put_byte(CH_COLON);
            n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
            for (i = 0; i < n; i++) begin
                if (i > 0) put_byte(CH_SEMI);
                put_element(1'b0);
            end
            if ($urandom_range(0, 1)) begin
                put_byte(CH_QUERY);
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++) begin
                    if (i > 0) put_byte(CH_AMP);
                    put_element(1'b1);
                end
            end
            if ($urandom_range(0, 15) == 0) put_byte($urandom_range(0, 1) ? CH_SEMI : CH_AMP);
        end
        if (uri_buf.size() == 0) put_byte(CH_COLON);
        flush_uri();
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PREFIX_TEXT) pfx_text = val;
        else pfx_len = val[3:0];
    endtask

    task automatic wait_idle();
        while (pending_chars.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [63:0] text, input logic [3:0] len,
                             input int budget, input bit with_directed);
        int start;
        wait_idle();
        write_reg(CFG_PREFIX_TEXT, text);
        write_reg(CFG_PREFIX_LENGTH, {60'd0, len});
        if (with_directed) begin
            put_byte(CH_COLON);
            flush_uri();
            put_byte(CH_QUERY);
            flush_uri();
            put_str(":comment=%4a%g?mkvp=");
            put_byte(8'h00);
            put_byte(CH_AMP);
            flush_uri();
            put_str(":?");
            flush_uri();
        end
        start = chars_queued;
        while (chars_queued - start < budget) gen_uri();
    endtask

    // input side: bursts with gaps, hold until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_char(s_tdata, s_tlast);
                pending_chars.delete(0);
                if (burst_left > 0) burst_left--;
            end
            if (!s_tvalid || s_tready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 7);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_chars[0].ch;
                    s_tlast  <= pending_chars[0].fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        stall_tick++;
        case ((stall_tick / 97) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 2) != 0);
            default: m_tready <= ((stall_tick % 6) < 4);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = '{m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[13:11], m_tlast};
            if (results_due.size() == 0) begin
                fail_count++;
                $display("%0t: mismatch expected none actual %0d/%0d/%02h/%0d/%0d",
                         $time, got_res.kind, got_res.attr, got_res.data,
                         got_res.status, got_res.fin);
            end else begin
                want_res = results_due.pop_front();
                if (got_res.kind !== want_res.kind || got_res.attr !== want_res.attr ||
                    got_res.data !== want_res.data || got_res.status !== want_res.status ||
                    got_res.fin !== want_res.fin) begin
                    fail_count++;
                    $display("%0t: mismatch expected %0d/%0d/%02h/%0d/%0d %s",
                             $time, want_res.kind, want_res.attr, want_res.data,
                             want_res.status, want_res.fin,
                             $sformatf("actual %0d/%0d/%02h/%0d/%0d", got_res.kind,
                                       got_res.attr, got_res.data, got_res.status,
                                       got_res.fin));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int drain;
        reset_uri();
        pfx_text = 64'd0;
        pfx_len  = 4'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        run_phase({$urandom, $urandom}, 4'd0, 50, 1'b1);
        run_phase(64'h0000_0000_7965_6B70, 4'd4, 50, 1'b0);
        run_phase({64{1'b1}}, 4'd8, 45, 1'b0);
        run_phase(64'd0, 4'd8, 45, 1'b0);
        run_phase({$urandom, $urandom}, 4'($urandom_range(1, 7)), 45, 1'b0);
        while (pending_chars.size() != 0 || s_tvalid) @(posedge aclk);
        drain = 0;
        while (results_due.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);
        while (results_due.size() != 0) begin
            want_res = results_due.pop_front();
            fail_count++;
            $display("%0t: mismatch expected %0d/%0d/%02h/%0d/%0d actual none",
                     $time, want_res.kind, want_res.attr, want_res.data,
                     want_res.status, want_res.fin);
        end
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
